// ===== design/dq_pkg.sv =====
// Shared constants and types for the double-ended byte queue.
// No dependencies; the top level refers to everything here by scoped name.
`default_nettype none

package dq_pkg;

   // queue geometry
   localparam int DEPTH  = 16;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = $clog2(2 * DEPTH);

   // fixed beat field widths
   localparam int CMD_W  = 3;
   localparam int BYTE_W = 8;
   localparam int OCC_W  = 5;
   localparam int REQ_W  = 16;
   localparam int RSP_W  = 16;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   // status carried alongside the store read
   typedef struct packed {
      logic             is_pop;
      logic             underflow;
      logic             overflow;
      logic [OCC_W-1:0] occupancy;
      logic             is_empty;
   } status_type;

endpackage

`default_nettype wire

// ===== design/double_ended_queue_unit.sv =====
// Double-ended byte queue over a circular store with a registered read.
// Depends on dq_pkg for geometry, command codes and the status struct.
//
//  channel | dir | tdata fields (lsb first)
//  req     | in  | cmd[2:0], push_byte[10:3], zero[15:11]
//  rsp     | out | popped_byte[7:0], underflow[8], overflow[9],
//          |     | occupancy[14:10], is_empty[15]
//
// One command per cycle while rsp is not stalled; a result passes these registers:
// the store read and the status stage, both loaded at the accept edge, then the
// output register. The command beat updates front pointer and fill count at
// once, so back-to-back commands see current pointers without forwarding.
// Reset clears pointers, count and the valid bits; store contents stay
// unknown and are never returned before written. A stalled rsp backs up into the
// status stage and then holds req_tready low.
`default_nettype none

module double_ended_queue_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // cmd, push_byte, zero pad
   input  wire  [dq_pkg::REQ_W-1:0]     req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // popped_byte, underflow, overflow, occupancy, is_empty
   output logic [dq_pkg::RSP_W-1:0]     rsp_tdata
);

   // store and pointers
   logic [dq_pkg::BYTE_W-1:0] mem [dq_pkg::DEPTH];
   logic [dq_pkg::ADDR_W-1:0] front_ff, front_in;
   logic [dq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [dq_pkg::BYTE_W-1:0] rd_data_ff;

   // status stage and output register
   logic                pend_valid_ff;
   dq_pkg::status_type  pend_ff, pend_in;
   logic                rsp_valid_ff;
   logic [dq_pkg::RSP_W-1:0] rsp_data_ff;

   logic [dq_pkg::CMD_W-1:0]  cmd;
   logic [dq_pkg::BYTE_W-1:0] push_byte;
   logic                      accept, pend_move;
   logic                      full, empty, wr_en;
   logic [dq_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic [dq_pkg::SUM_W-1:0]  back_sum, last_sum;
   logic [dq_pkg::ADDR_W-1:0] back_slot, last_slot;
   logic [dq_pkg::BYTE_W-1:0] popped;

   assign cmd       = req_tdata[dq_pkg::CMD_W-1:0];
   assign push_byte = req_tdata[dq_pkg::CMD_W +: dq_pkg::BYTE_W];

   // handshake: status stage drains into output register when it is free
   assign pend_move  = pend_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_valid_ff || pend_move;
   assign accept     = req_tvalid && req_tready;

   assign full  = (count_ff == dq_pkg::CNT_W'(dq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   // slot just past the back, and slot of the last element (wrap by one compare)
   always_comb begin
      back_sum = dq_pkg::SUM_W'(front_ff) + dq_pkg::SUM_W'(count_ff);
      if (back_sum >= dq_pkg::SUM_W'(dq_pkg::DEPTH)) begin
         back_sum = back_sum - dq_pkg::SUM_W'(dq_pkg::DEPTH);
      end
      back_slot = back_sum[dq_pkg::ADDR_W-1:0];
      last_sum  = dq_pkg::SUM_W'(front_ff) + dq_pkg::SUM_W'(count_ff)
                  - dq_pkg::SUM_W'(1);
      if (last_sum >= dq_pkg::SUM_W'(dq_pkg::DEPTH)) begin
         last_sum = last_sum - dq_pkg::SUM_W'(dq_pkg::DEPTH);
      end
      last_slot = last_sum[dq_pkg::ADDR_W-1:0];
   end

   // command decode
   always_comb begin
      front_in          = front_ff;
      count_in          = count_ff;
      wr_en             = 1'b0;
      wr_addr           = front_ff;
      rd_addr           = front_ff;
      pend_in.is_pop    = 1'b0;
      pend_in.underflow = 1'b0;
      pend_in.overflow  = 1'b0;
      case (cmd)
         dq_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
               pend_in.overflow = 1'b1;
            end else begin
               front_in = (front_ff == '0) ? dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1)
                                           : front_ff - dq_pkg::ADDR_W'(1);
               wr_en    = 1'b1;
               wr_addr  = front_in;
               count_in = count_ff + dq_pkg::CNT_W'(1);
            end
         end
         dq_pkg::CMD_PUSH_BACK: begin
            if (full) begin
               pend_in.overflow = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = back_slot;
               count_in = count_ff + dq_pkg::CNT_W'(1);
            end
         end
         dq_pkg::CMD_POP_FRONT: begin
            if (empty) begin
               pend_in.underflow = 1'b1;
            end else begin
               pend_in.is_pop = 1'b1;
               rd_addr  = front_ff;
               front_in = (front_ff == dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1))
                          ? '0 : front_ff + dq_pkg::ADDR_W'(1);
               count_in = count_ff - dq_pkg::CNT_W'(1);
            end
         end
         dq_pkg::CMD_POP_BACK: begin
            if (empty) begin
               pend_in.underflow = 1'b1;
            end else begin
               pend_in.is_pop = 1'b1;
               rd_addr  = last_slot;
               count_in = count_ff - dq_pkg::CNT_W'(1);
            end
         end
         dq_pkg::CMD_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
      pend_in.occupancy = dq_pkg::OCC_W'(count_in);
      pend_in.is_empty  = (count_in == '0);
   end

   // store: one write and one registered read per command beat
   always_ff @(posedge clock) begin
      if (accept) begin
         if (wr_en) begin
            mem[wr_addr] <= push_byte;
         end
         rd_data_ff <= mem[rd_addr];
      end
   end

   // pointers and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
         if (accept) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_move) begin
            pend_valid_ff <= 1'b0;
         end
         if (pend_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   assign popped = pend_ff.is_pop ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (pend_move) begin
         rsp_data_ff <= {pend_ff.is_empty, pend_ff.occupancy, pend_ff.overflow,
                         pend_ff.underflow, popped};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
      else $error("fill count beyond depth");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> !(pend_ff.underflow && pend_ff.overflow))
      else $error("underflow and overflow together");

   a_empty_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[15] == (rsp_data_ff[14:10] == '0)))
      else $error("empty flag disagrees with occupancy");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == dq_pkg::CMD_CLEAR) |=> (count_ff == '0 && front_ff == '0))
      else $error("clear left pointers set");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && pend_ff.is_pop) |-> !pend_ff.underflow)
      else $error("pop marked with underflow");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for double_ended_queue_unit: command beats with random gaps,
// result beats under random back-pressure, each result checked against a deque predictor.
// Depends on dq_pkg for field widths, depth and command codes.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // codes outside the enum that the block must treat as no-ops
   localparam logic [dq_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [dq_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
   localparam int RANDOM_CMDS = 950;
   localparam int QUIET_LIMIT = 500;
   localparam int DRAIN_CYCLES = 8;

   // req tdata layout, msb first
   typedef struct packed {
      logic [4:0]                  pad;
      logic [dq_pkg::BYTE_W-1:0]   push_byte;
      logic [dq_pkg::CMD_W-1:0]    cmd;
   } req_fields_type;

   // rsp tdata layout, msb first
   typedef struct packed {
      logic                        is_empty;
      logic [dq_pkg::OCC_W-1:0]    occupancy;
      logic                        overflow;
      logic                        underflow;
      logic [dq_pkg::BYTE_W-1:0]   popped_byte;
   } rsp_fields_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // cmd, push_byte, zero pad
   logic [dq_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // popped_byte, underflow, overflow, occupancy, is_empty
   logic [dq_pkg::RSP_W-1:0] rsp_tdata;

   double_ended_queue_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // shadow deque
   logic [dq_pkg::BYTE_W-1:0] shadow_store [dq_pkg::DEPTH];
   int shadow_front = 0;
   int shadow_fill = 0;

   req_fields_type cmd_backlog [$];
   rsp_fields_type pending_answers [$];
   int mismatches = 0;
   int quiet_cycles = 0;

   // handshake bookkeeping between the rising and falling edge processes
   bit req_took = 1'b0;
   bit rsp_took = 1'b0;
   int req_hold = 0;
   int rsp_wait = 0;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;

   // applies one command to the shadow deque and returns the result it should produce
   function automatic rsp_fields_type deque_apply(input logic [dq_pkg::CMD_W-1:0] op,
                                                  input logic [dq_pkg::BYTE_W-1:0] data);
      rsp_fields_type res;
      res = '0;
      case (op)
         dq_pkg::CMD_PUSH_FRONT: begin
            if (shadow_fill >= dq_pkg::DEPTH) res.overflow = 1'b1;
            else begin
               shadow_front = (shadow_front + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
               shadow_store[shadow_front] = data;
               shadow_fill++;
            end
         end
         dq_pkg::CMD_PUSH_BACK: begin
            if (shadow_fill >= dq_pkg::DEPTH) res.overflow = 1'b1;
            else begin
               shadow_store[(shadow_front + shadow_fill) % dq_pkg::DEPTH] = data;
               shadow_fill++;
            end
         end
         dq_pkg::CMD_POP_FRONT: begin
            if (shadow_fill == 0) res.underflow = 1'b1;
            else begin
               res.popped_byte = shadow_store[shadow_front];
               shadow_front = (shadow_front + 1) % dq_pkg::DEPTH;
               shadow_fill--;
            end
         end
         dq_pkg::CMD_POP_BACK: begin
            if (shadow_fill == 0) res.underflow = 1'b1;
            else begin
               res.popped_byte = shadow_store[(shadow_front + shadow_fill - 1) % dq_pkg::DEPTH];
               shadow_fill--;
            end
         end
         dq_pkg::CMD_CLEAR: begin
            shadow_fill = 0;
            shadow_front = 0;
         end
         default: ;
      endcase
      res.occupancy = dq_pkg::OCC_W'(shadow_fill);
      res.is_empty = (shadow_fill == 0);
      return res;
   endfunction

   // idle cycles before the next beat; occasionally flips into or out of a no-idle stretch
   function automatic int draw_wait(inout bit steady);
      if ($urandom_range(0, 39) == 0) steady = !steady;
      return steady ? 0 : int'($urandom_range(0, 8));
   endfunction

   task automatic add_cmd(input logic [dq_pkg::CMD_W-1:0] op,
                          input logic [dq_pkg::BYTE_W-1:0] data);
      req_fields_type beat;
      beat = '0;
      beat.cmd = op;
      beat.push_byte = data;
      cmd_backlog.push_back(beat);
   endtask

   // sample both channels at the rising edge: predict on req beats, check rsp beats
   always @(posedge clock) begin
      req_fields_type got_req;
      rsp_fields_type got_rsp;
      rsp_fields_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            got_req = req_tdata;
            pending_answers.push_back(deque_apply(got_req.cmd, got_req.push_byte));
            req_took = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_tdata;
            rsp_took = 1'b1;
            if (pending_answers.size() == 0) begin
               $error("result beat with nothing outstanding: tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               want = pending_answers.pop_front();
               if (got_rsp.popped_byte !== want.popped_byte) begin
                  $error("popped_byte: expected %h, got %h", want.popped_byte,
                         got_rsp.popped_byte);
                  mismatches++;
               end
               if (got_rsp.underflow !== want.underflow) begin
                  $error("underflow: expected %b, got %b", want.underflow, got_rsp.underflow);
                  mismatches++;
               end
               if (got_rsp.overflow !== want.overflow) begin
                  $error("overflow: expected %b, got %b", want.overflow, got_rsp.overflow);
                  mismatches++;
               end
               if (got_rsp.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy,
                         got_rsp.occupancy);
                  mismatches++;
               end
               if (got_rsp.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %b, got %b", want.is_empty, got_rsp.is_empty);
                  mismatches++;
               end
            end
         end
      end
   end

   // watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // command driver: next beat from the backlog after a random gap
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (req_hold > 0) begin
            req_hold--;
            req_tvalid <= 1'b0;
         end else if (cmd_backlog.size() != 0) begin
            req_tdata <= cmd_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_hold = draw_wait(req_steady);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_took = 1'b0;
   end

   // result sink: random stall before each beat
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_took) rsp_wait = draw_wait(rsp_steady);
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
      rsp_took = 1'b0;
   end

   // stimulus, reset and end of run
   initial begin
      int phase_left;
      int push_pct;
      int roll;
      logic [dq_pkg::BYTE_W-1:0] data;

      // directed: empty pops, no-op codes, fill to full, overflow both ends, pops at both ends, clear
      add_cmd(dq_pkg::CMD_POP_FRONT, 8'hFF);
      add_cmd(dq_pkg::CMD_POP_BACK, 8'h00);
      add_cmd(CMD_UNUSED_LO, 8'hAA);
      for (int i = 0; i < dq_pkg::DEPTH; i++)
         add_cmd((i % 2 == 0) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK, 8'(i * 17));
      add_cmd(dq_pkg::CMD_PUSH_BACK, 8'h55);
      add_cmd(dq_pkg::CMD_PUSH_FRONT, 8'hAA);
      add_cmd(dq_pkg::CMD_POP_FRONT, 8'h00);
      add_cmd(dq_pkg::CMD_POP_BACK, 8'h00);
      add_cmd(CMD_UNUSED_LO + 3'd1, 8'h55);
      add_cmd(CMD_UNUSED_HI, 8'hFF);
      add_cmd(dq_pkg::CMD_CLEAR, 8'h00);
      add_cmd(dq_pkg::CMD_POP_FRONT, 8'h00);

      // random: phases biased toward filling or draining so occupancy sweeps empty to full
      phase_left = 0;
      push_pct = 50;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
               0: push_pct = 80;
               1: push_pct = 20;
               default: push_pct = 50;
            endcase
         end
         phase_left--;
         data = dq_pkg::BYTE_W'($urandom_range(0, 255));
         roll = $urandom_range(0, 99);
         if (roll < 2) add_cmd(dq_pkg::CMD_CLEAR, data);
         else if (roll < 4)
            add_cmd(dq_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), data);
         else if ($urandom_range(0, 99) < push_pct)
            add_cmd($urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK, data);
         else
            add_cmd($urandom_range(0, 1) ? dq_pkg::CMD_POP_FRONT : dq_pkg::CMD_POP_BACK, data);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: wait until everything is sent and every result is back
      do @(posedge clock);
      while (cmd_backlog.size() != 0 || req_tvalid || pending_answers.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
